// ===== sv/bgr_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap glyph rasterizer package
// Shared types, constants and the 3x5 font table.
// ----------------------------------------------------------------------------
package bgr_pkg;

  localparam int CELL_W     = 3;
  localparam int CELL_H     = 5;
  localparam int GLYPH_BITS = CELL_W * CELL_H;

  typedef logic [7:0]            char_t;
  typedef logic [11:0]           pos12_t;
  typedef logic [15:0]           coord_t;
  typedef logic [3:0]            scale_t;
  typedef logic [7:0]            chan_t;
  typedef logic [GLYPH_BITS-1:0] glyph_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_ADV
  } state_t;

  // Font lookup. Rows top first, column 0 in the upper bit of each row, so the
  // scan order is MSB first. Lower-case letters fold to upper case; any other
  // code, including space, gives an empty glyph.
  function automatic glyph_t glyph_lookup(input char_t code);
    char_t c;
    glyph_t g;
    c = code;
    if (code >= 8'h61 && code <= 8'h7A) begin
      c = code - 8'h20;
    end
    case (c)
      "0":     g = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      "1":     g = {3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
      "2":     g = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
      "3":     g = {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
      "4":     g = {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
      "5":     g = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      "6":     g = {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
      "7":     g = {3'd7, 3'd1, 3'd1, 3'd1, 3'd1};
      "8":     g = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
      "9":     g = {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
      "A":     g = {3'd7, 3'd5, 3'd7, 3'd5, 3'd5};
      "B":     g = {3'd6, 3'd5, 3'd6, 3'd5, 3'd6};
      "C":     g = {3'd7, 3'd4, 3'd4, 3'd4, 3'd7};
      "D":     g = {3'd6, 3'd5, 3'd5, 3'd5, 3'd6};
      "E":     g = {3'd7, 3'd4, 3'd7, 3'd4, 3'd7};
      "F":     g = {3'd7, 3'd4, 3'd7, 3'd4, 3'd4};
      "G":     g = {3'd7, 3'd4, 3'd5, 3'd5, 3'd7};
      "H":     g = {3'd5, 3'd5, 3'd7, 3'd5, 3'd5};
      "I":     g = {3'd7, 3'd2, 3'd2, 3'd2, 3'd7};
      "J":     g = {3'd1, 3'd1, 3'd1, 3'd5, 3'd7};
      "K":     g = {3'd5, 3'd5, 3'd6, 3'd5, 3'd5};
      "L":     g = {3'd4, 3'd4, 3'd4, 3'd4, 3'd7};
      "M":     g = {3'd5, 3'd7, 3'd7, 3'd5, 3'd5};
      "N":     g = {3'd6, 3'd5, 3'd5, 3'd5, 3'd5};
      "O":     g = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      "P":     g = {3'd7, 3'd5, 3'd7, 3'd4, 3'd4};
      "Q":     g = {3'd7, 3'd5, 3'd5, 3'd7, 3'd3};
      "R":     g = {3'd7, 3'd5, 3'd6, 3'd5, 3'd5};
      "S":     g = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      "T":     g = {3'd7, 3'd2, 3'd2, 3'd2, 3'd2};
      "U":     g = {3'd5, 3'd5, 3'd5, 3'd5, 3'd7};
      "V":     g = {3'd5, 3'd5, 3'd5, 3'd5, 3'd2};
      "W":     g = {3'd5, 3'd5, 3'd7, 3'd7, 3'd5};
      "X":     g = {3'd5, 3'd5, 3'd2, 3'd5, 3'd5};
      "Y":     g = {3'd5, 3'd5, 3'd2, 3'd2, 3'd2};
      "Z":     g = {3'd7, 3'd1, 3'd2, 3'd4, 3'd7};
      ".":     g = {3'd0, 3'd0, 3'd0, 3'd0, 3'd2};
      "-":     g = {3'd0, 3'd0, 3'd7, 3'd0, 3'd0};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ===== sv/bgr_if.sv =====
// ----------------------------------------------------------------------------
// Bitmap glyph rasterizer channel interfaces
// Valid/ready channels for character items and dot fill commands.
// ----------------------------------------------------------------------------

// Character channel.
interface bgr_in_if;
  logic              valid;
  logic              ready;
  bgr_pkg::char_t    char_code;
  logic              text_start;
  bgr_pkg::pos12_t   origin_x;
  bgr_pkg::pos12_t   line_y;
  bgr_pkg::chan_t    red;
  bgr_pkg::chan_t    green;
  bgr_pkg::chan_t    blue;

  modport source (output valid, char_code, text_start, origin_x, line_y, red, green, blue,
                  input ready);
  modport sink   (input valid, char_code, text_start, origin_x, line_y, red, green, blue,
                  output ready);
endinterface

// Dot fill command channel.
interface bgr_out_if;
  logic              valid;
  logic              ready;
  bgr_pkg::coord_t   rect_x;
  bgr_pkg::coord_t   rect_y;
  bgr_pkg::scale_t   rect_size;
  bgr_pkg::chan_t    fill_red;
  bgr_pkg::chan_t    fill_green;
  bgr_pkg::chan_t    fill_blue;
  logic              last_dot;

  modport source (output valid, rect_x, rect_y, rect_size, fill_red, fill_green, fill_blue,
                  last_dot, input ready);
  modport sink   (input valid, rect_x, rect_y, rect_size, fill_red, fill_green, fill_blue,
                  last_dot, output ready);
endinterface

// ===== sv/bitmap_glyph_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Bitmap glyph rasterizer
// Turns text characters into square dot fill commands with a 3x5 font.
// ----------------------------------------------------------------------------
//   Channel  | Direction | Handshake          | Carries
//   in_ch    | in        | valid/ready        | one character with position and color
//   out_ch   | out       | valid/ready        | one dot fill command
//   cfg_*    | in        | write enable only  | dot scale register
//
// After a character transaction the sequencer passes through LOAD, SCAN and ADV
// before it is ready again, so a new character is taken only once the last one is
// done; the scan shifts out the glyph bits in order and stops after the last set bit.
// Each dot waits for the output register to drain, so a stalled sink stretches
// the scan.
// Reset is synchronous and active low; it clears the pen, the scale to 1 and
// the output valid flag.
// ----------------------------------------------------------------------------
module bitmap_glyph_rasterizer #(
  parameter int ADVANCE_PIXELS = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  bgr_in_if.sink          in_ch,
  bgr_out_if.source       out_ch,
  input  logic            cfg_wr_en,
  input  bgr_pkg::scale_t cfg_wr_data
);
  import bgr_pkg::*;

  localparam int ADV_MAX = ADVANCE_PIXELS * 15;
  localparam int ADV_W   = $clog2(ADV_MAX + 1);
  localparam int B_W     = (ADV_W > 5) ? ADV_W : 5;

  state_t          state_r, state_nxt;
  scale_t          scale_r;
  coord_t          pen_r;
  pos12_t          line_y_r;
  chan_t           red_r, green_r, blue_r;
  glyph_t          glyph_r;
  glyph_t          rom_glyph;
  logic [1:0]      col_r;
  logic [4:0]      x_off_r;
  logic [5:0]      y_off_r;
  logic            out_valid_r;
  coord_t          rect_x_r, rect_y_r;
  scale_t          rect_size_r;
  chan_t           fill_red_r, fill_green_r, fill_blue_r;
  logic            last_dot_r;

  scale_t          s_eff;
  logic [ADV_W-1:0] adv;
  logic [B_W-1:0]  add_b;
  coord_t          add_sum;
  logic            in_xfer;
  logic            out_free;
  logic            step;
  logic            emit;

  // Effective scale and pen advance.
  assign s_eff = (scale_r == '0) ? 4'd1 : scale_r;
  assign adv   = ADV_W'(ADVANCE_PIXELS) * ADV_W'(s_eff);

  // Handshake terms.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign step        = (state_r == ST_SCAN) && (glyph_r != '0) && (!glyph_r[GLYPH_BITS-1] ||
                       out_free);
  assign emit        = step && glyph_r[GLYPH_BITS-1];

  // Font lookup of the incoming character.
  bgr_font_rom u_rom (
    .clk     (clk),
    .code    (in_ch.char_code),
    .glyph_q (rom_glyph)
  );

  // Shared adder: dot x during the scan, pen advance afterwards.
  assign add_b = (state_r == ST_ADV) ? B_W'(adv) : B_W'(x_off_r);

  bgr_sat_add #(.B_W(B_W)) u_add (
    .a   (pen_r),
    .b   (add_b),
    .sum (add_sum)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_SCAN;
      ST_SCAN: if (glyph_r == '0) state_nxt = ST_ADV;
      ST_ADV:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Scale register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 4'd1;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  // Pen register: loaded from the origin at a string start, advanced after each
  // character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r <= '0;
    end else if (in_xfer && in_ch.text_start) begin
      pen_r <= {4'd0, in_ch.origin_x};
    end else if (state_r == ST_ADV) begin
      pen_r <= add_sum;
    end
  end

  // Per-character payload latched at acceptance.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      line_y_r <= in_ch.line_y;
      red_r    <= in_ch.red;
      green_r  <= in_ch.green;
      blue_r   <= in_ch.blue;
    end
  end

  // Glyph shift register and cell position counters.
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      glyph_r <= rom_glyph;
      col_r   <= '0;
      x_off_r <= '0;
      y_off_r <= '0;
    end else if (step) begin
      glyph_r <= {glyph_r[GLYPH_BITS-2:0], 1'b0};
      if (col_r == 2'(CELL_W - 1)) begin
        col_r   <= '0;
        x_off_r <= '0;
        y_off_r <= y_off_r + 6'(s_eff);
      end else begin
        col_r   <= col_r + 2'd1;
        x_off_r <= x_off_r + 5'(s_eff);
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      rect_x_r     <= add_sum;
      rect_y_r     <= {4'd0, line_y_r} + {10'd0, y_off_r};
      rect_size_r  <= s_eff;
      fill_red_r   <= red_r;
      fill_green_r <= green_r;
      fill_blue_r  <= blue_r;
      last_dot_r   <= (glyph_r[GLYPH_BITS-2:0] == '0);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.rect_x     = rect_x_r;
  assign out_ch.rect_y     = rect_y_r;
  assign out_ch.rect_size  = rect_size_r;
  assign out_ch.fill_red   = fill_red_r;
  assign out_ch.fill_green = fill_green_r;
  assign out_ch.fill_blue  = fill_blue_r;
  assign out_ch.last_dot   = last_dot_r;

endmodule

// ===== sv/bgr_font_rom.sv =====
// ----------------------------------------------------------------------------
// Bitmap glyph rasterizer font ROM
// Registered 3x5 glyph lookup with lower-case folding.
// ----------------------------------------------------------------------------
module bgr_font_rom (
  input  logic            clk,
  input  bgr_pkg::char_t  code,
  output bgr_pkg::glyph_t glyph_q
);
  import bgr_pkg::*;

  glyph_t glyph_r;

  // Look up the glyph and register it for the sequencer.
  always_ff @(posedge clk) begin
    glyph_r <= glyph_lookup(code);
  end

  assign glyph_q = glyph_r;

endmodule

// ===== sv/bgr_sat_add.sv =====
// ----------------------------------------------------------------------------
// Bitmap glyph rasterizer saturating adder
// Shared 16-bit add that clamps at 65535, used for dot x and pen advance.
// ----------------------------------------------------------------------------
module bgr_sat_add #(
  parameter int B_W = 7
) (
  input  bgr_pkg::coord_t a,
  input  logic [B_W-1:0]  b,
  output bgr_pkg::coord_t sum
);
  import bgr_pkg::*;

  logic [16:0] full;

  // Widen, add and clamp on carry out.
  assign full = {1'b0, a} + {{(17 - B_W){1'b0}}, b};
  assign sum  = full[16] ? 16'hFFFF : full[15:0];

endmodule

// ===== sv/bgr_checker.sv =====
// ----------------------------------------------------------------------------
// Bitmap glyph rasterizer port checker
// Watches the top-level ports and flags protocol or sequencing slips.
// ----------------------------------------------------------------------------
module bgr_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input bgr_pkg::coord_t rect_x,
  input bgr_pkg::scale_t rect_size
);
  import bgr_pkg::*;

  // A character transaction makes the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a character transaction");

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Every dot command has a nonzero size.
  a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> rect_size != '0)
    else $error("dot command with zero size");

  // A stalled command stays offered with the same x.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(rect_x))
    else $error("stalled dot command dropped or changed");

endmodule

bind bitmap_glyph_rasterizer bgr_checker u_bgr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .rect_x    (out_ch.rect_x),
  .rect_size (out_ch.rect_size)
);

// ===== verif/glyph_dot_checker.sv =====
// ----------------------------------------------------------------------------
// Glyph dot checker
// Watches the character and dot command channels of the glyph rasterizer.
// Each accepted character is expanded into its expected dot commands with a
// private copy of the 3x5 font, the pen position and the scale register, and
// each accepted dot command is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module glyph_dot_checker #(
  parameter int ADVANCE_PIXELS = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  bgr_in_if               in_ch,
  bgr_out_if              out_ch,
  input  logic            cfg_wr_en,
  input  bgr_pkg::scale_t cfg_wr_data,
  output int              fail_count,
  output int              dots_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bgr_pkg::*;

  localparam int COORD_MAX  = 65535;
  localparam int NUM_GLYPHS = 38;
  localparam int IDX_DIGIT  = 0;
  localparam int IDX_LETTER = 10;
  localparam int IDX_PERIOD = 36;
  localparam int IDX_DASH   = 37;
  localparam int NO_GLYPH   = -1;

  // Font bitmaps, row 0 first; within a row the leftmost column is the upper bit.
  localparam glyph_t FONT_ROM [NUM_GLYPHS] = '{
    15'b111_101_101_101_111, 15'b010_110_010_010_111, 15'b111_001_111_100_111,
    15'b111_001_111_001_111, 15'b101_101_111_001_001, 15'b111_100_111_001_111,
    15'b111_100_111_101_111, 15'b111_001_001_001_001, 15'b111_101_111_101_111,
    15'b111_101_111_001_111,
    15'b111_101_111_101_101, 15'b110_101_110_101_110, 15'b111_100_100_100_111,
    15'b110_101_101_101_110, 15'b111_100_111_100_111, 15'b111_100_111_100_100,
    15'b111_100_101_101_111, 15'b101_101_111_101_101, 15'b111_010_010_010_111,
    15'b001_001_001_101_111, 15'b101_101_110_101_101, 15'b100_100_100_100_111,
    15'b101_111_111_101_101, 15'b110_101_101_101_101, 15'b111_101_101_101_111,
    15'b111_101_111_100_100, 15'b111_101_101_111_011, 15'b111_101_110_101_101,
    15'b111_100_111_001_111, 15'b111_010_010_010_010, 15'b101_101_101_101_111,
    15'b101_101_101_101_010, 15'b101_101_111_111_101, 15'b101_101_010_101_101,
    15'b101_101_010_010_010, 15'b111_001_010_100_111,
    15'b000_000_000_000_010, 15'b000_000_111_000_000
  };

  typedef struct packed {
    coord_t rect_x;
    coord_t rect_y;
    scale_t rect_size;
    chan_t  red;
    chan_t  green;
    chan_t  blue;
    logic   last_dot;
  } dot_cmd_t;

  dot_cmd_t dot_queue [$];
  scale_t   dot_scale;
  int       pen_pos;

  function automatic int sat_coord(input int v);
    return (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // Maps a character byte to its font slot; lower case folds to upper case.
  function automatic int font_index(input char_t code);
    char_t c;
    c = code;
    if (c >= "a" && c <= "z") begin
      c = c - 8'h20;
    end
    if (c >= "0" && c <= "9") begin
      return IDX_DIGIT + int'(c - "0");
    end
    if (c >= "A" && c <= "Z") begin
      return IDX_LETTER + int'(c - "A");
    end
    if (c == ".") begin
      return IDX_PERIOD;
    end
    if (c == "-") begin
      return IDX_DASH;
    end
    return NO_GLYPH;
  endfunction

  // Expands one character into dot commands and advances the pen.
  task automatic rasterize_glyph(input char_t code, input logic start, input pos12_t ox,
                                 input pos12_t ly, input chan_t r, input chan_t g,
                                 input chan_t b);
    int       s;
    int       idx;
    int       row;
    int       col;
    int       total;
    int       drawn;
    glyph_t   bits;
    dot_cmd_t d;
    s = (dot_scale == '0) ? 1 : int'(dot_scale);
    if (start) begin
      pen_pos = int'(ox);
    end
    idx = font_index(code);
    if (idx != NO_GLYPH) begin
      bits  = FONT_ROM[idx];
      total = $countones(bits);
      drawn = 0;
      for (int i = GLYPH_BITS - 1; i >= 0; i--) begin
        if (bits[i]) begin
          row         = (GLYPH_BITS - 1 - i) / CELL_W;
          col         = (GLYPH_BITS - 1 - i) % CELL_W;
          drawn++;
          d.rect_x    = coord_t'(sat_coord(pen_pos + col * s));
          d.rect_y    = coord_t'(sat_coord(int'(ly) + row * s));
          d.rect_size = scale_t'(s);
          d.red       = r;
          d.green     = g;
          d.blue      = b;
          d.last_dot  = (drawn == total);
          dot_queue.insert(dot_queue.size(), d);
        end
      end
    end
    pen_pos = sat_coord(pen_pos + ADVANCE_PIXELS * s);
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Compares one accepted dot command with the oldest expected one.
  task automatic check_dot();
    dot_cmd_t want;
    if (dot_queue.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected dot command, expected none, actual x=%0d y=%0d",
               $time, out_ch.rect_x, out_ch.rect_y);
    end else begin
      want = dot_queue[0];
      dot_queue.delete(0);
      check_field("rect_x",     want.rect_x,     out_ch.rect_x);
      check_field("rect_y",     want.rect_y,     out_ch.rect_y);
      check_field("rect_size",  want.rect_size,  out_ch.rect_size);
      check_field("fill_red",   want.red,        out_ch.fill_red);
      check_field("fill_green", want.green,      out_ch.fill_green);
      check_field("fill_blue",  want.blue,       out_ch.fill_blue);
      check_field("last_dot",   want.last_dot,   out_ch.last_dot);
    end
  endtask

  initial begin
    fail_count   = 0;
    dots_pending = 0;
    dot_scale    = 4'd1;
    pen_pos      = 0;
  end

  // Track register writes, check dot transactions, then predict new characters.
  always @(posedge clk) begin
    if (!rst_n) begin
      dot_scale = 4'd1;
      pen_pos   = 0;
      dot_queue.delete();
    end else begin
      if (cfg_wr_en) begin
        dot_scale = cfg_wr_data;
      end
      if (out_ch.valid && out_ch.ready) begin
        check_dot();
      end
      if (in_ch.valid && in_ch.ready) begin
        rasterize_glyph(in_ch.char_code, in_ch.text_start, in_ch.origin_x, in_ch.line_y,
                        in_ch.red, in_ch.green, in_ch.blue);
      end
    end
    dots_pending = dot_queue.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Glyph rasterizer testbench top
// Drives character transactions and the scale register into the rasterizer,
// accepts its dot commands with random back-pressure, and reports the verdict
// from the failure count of the glyph dot checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bgr_pkg::*;

  localparam int ADVANCE_PIXELS = 4;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int ITEMS_PER_MODE = 90;
  localparam int HOLD_CYCLES    = 300;
  localparam int NUM_MODES      = 4;

  logic   clk;
  logic   rst_n;
  logic   cfg_wr_en;
  scale_t cfg_wr_data;
  int     fail_count;
  int     dots_pending;
  int     send_idle_pct;
  int     stall_pct;
  bit     hold_out;
  int     items_sent;

  bgr_in_if  in_ch ();
  bgr_out_if out_ch ();

  bitmap_glyph_rasterizer #(
    .ADVANCE_PIXELS(ADVANCE_PIXELS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  glyph_dot_checker #(
    .ADVANCE_PIXELS(ADVANCE_PIXELS)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .dots_pending(dots_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Dot command sink: random stalls, plus a long hold-off when requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = !hold_out && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Run limit.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offers one character and returns at the edge where it is accepted.
  task automatic send_glyph(input char_t code, input logic start, input pos12_t ox,
                            input pos12_t ly, input chan_t r, input chan_t g,
                            input chan_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.char_code  = code;
    in_ch.text_start = start;
    in_ch.origin_x   = ox;
    in_ch.line_y     = ly;
    in_ch.red        = r;
    in_ch.green      = g;
    in_ch.blue       = b;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Lets all expected dots arrive and the block settle.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (dots_pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_scale(input scale_t value);
    wait_idle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  task automatic hold_output(input int cycles);
    hold_out = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_out = 1'b0;
  endtask

  // Mostly drawable characters, with spaces and arbitrary bytes mixed in.
  function automatic char_t pick_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      return char_t'("A" + $urandom_range(0, 25));
    end
    if (roll < 45) begin
      return char_t'("a" + $urandom_range(0, 25));
    end
    if (roll < 60) begin
      return char_t'("0" + $urandom_range(0, 9));
    end
    if (roll < 68) begin
      return $urandom_range(0, 1) ? char_t'(".") : char_t'("-");
    end
    if (roll < 78) begin
      return char_t'(" ");
    end
    return char_t'($urandom_range(0, 255));
  endfunction

  // One text string: usually opened by text_start, sometimes broken.
  task automatic send_text_run();
    int     len;
    logic   start;
    pos12_t ox;
    pos12_t ly;
    chan_t  r;
    chan_t  g;
    chan_t  b;
    len = $urandom_range(1, 12);
    ox  = pos12_t'($urandom_range(0, 4095));
    ly  = pos12_t'($urandom_range(0, 4095));
    r   = chan_t'($urandom_range(0, 255));
    g   = chan_t'($urandom_range(0, 255));
    b   = chan_t'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        start = ($urandom_range(0, 9) != 0);
      end else begin
        start = ($urandom_range(0, 19) == 0);
      end
      if (start && i != 0) begin
        ox = pos12_t'($urandom_range(0, 4095));
      end
      if ($urandom_range(0, 19) == 0) begin
        r = chan_t'($urandom_range(0, 255));
      end
      send_glyph(pick_char(), start, start ? ox : pos12_t'($urandom_range(0, 4095)),
                 ly, r, g, b);
    end
  endtask

  initial begin
    char_t  odd_codes [10];
    int     mode_send [NUM_MODES];
    int     mode_stall [NUM_MODES];
    scale_t mode_scale [NUM_MODES];
    odd_codes  = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'h3A, 8'h80, 8'hFF, 8'h20, 8'h00};
    mode_send  = '{0, 77, 0, 15};
    mode_stall = '{0, 0, 77, 15};
    mode_scale = '{4'd8, scale_t'($urandom_range(2, 7)), scale_t'($urandom_range(9, 14)),
                   4'd1};

    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_ch.valid      = 1'b0;
    in_ch.char_code  = '0;
    in_ch.text_start = 1'b0;
    in_ch.origin_x   = '0;
    in_ch.line_y     = '0;
    in_ch.red        = '0;
    in_ch.green      = '0;
    in_ch.blue       = '0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    hold_out         = 1'b0;
    items_sent       = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset scale, pen still at zero without text_start, then field extremes.
    send_glyph("A", 1'b0, 12'd4095, 12'd0, 8'd255, 8'd0, 8'd255);
    send_glyph("8", 1'b1, 12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
    send_glyph("a", 1'b0, 12'd0, 12'd4095, 8'd0, 8'd0, 8'd0);
    send_glyph("z", 1'b0, 12'd0, 12'd17, 8'd1, 8'd2, 8'd3);
    send_glyph("Z", 1'b0, 12'd0, 12'd17, 8'd128, 8'd64, 8'd32);
    send_glyph(".", 1'b1, 12'd0, 12'd0, 8'd9, 8'd8, 8'd7);
    send_glyph("-", 1'b0, 12'd0, 12'd0, 8'd9, 8'd8, 8'd7);
    // Space, bytes just outside the font ranges and the bytes 00, 80 and FF draw nothing but advance.
    foreach (odd_codes[i]) begin
      send_glyph(odd_codes[i], 1'b0, 12'd0, 12'd100, 8'd5, 8'd5, 8'd5);
    end
    send_glyph("M", 1'b0, 12'd0, 12'd100, 8'd200, 8'd100, 8'd50);
    send_glyph("Q", 1'b0, 12'd0, 12'd100, 8'd200, 8'd100, 8'd50);
    send_glyph("1", 1'b0, 12'd0, 12'd100, 8'd200, 8'd100, 8'd50);

    // A zero scale behaves as one.
    write_scale(4'd0);
    send_glyph("W", 1'b1, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
    send_glyph("7", 1'b0, 12'd0, 12'd0, 8'd255, 8'd255, 8'd255);

    // Largest scale: widest dot offsets and pen steps, starting at the far
    // right of the origin range and the bottom text row.
    write_scale(4'd15);
    send_glyph("-", 1'b1, 12'd4080, 12'd4095, 8'd10, 8'd20, 8'd30);
    repeat (8) begin
      send_glyph(" ", 1'b0, pos12_t'($urandom_range(0, 4095)), 12'd4095,
                 8'd10, 8'd20, 8'd30);
    end
    send_glyph("W", 1'b0, 12'd0, 12'd4095, 8'd40, 8'd50, 8'd60);
    send_glyph("8", 1'b0, 12'd0, 12'd4095, 8'd40, 8'd50, 8'd60);
    send_glyph(" ", 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
    send_glyph("m", 1'b0, 12'd0, 12'd0, 8'd70, 8'd80, 8'd90);

    // Random strings under each idling mode; the first also stalls the sink
    // for a long stretch while characters keep coming.
    for (int m = 0; m < NUM_MODES; m++) begin
      write_scale(mode_scale[m]);
      send_idle_pct = mode_send[m];
      stall_pct     = mode_stall[m];
      if (m == 0) begin
        fork
          hold_output(HOLD_CYCLES);
        join_none
      end
      items_sent = 0;
      while (items_sent < ITEMS_PER_MODE) begin
        send_text_run();
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== bitmap_glyph_rasterizer.f =====
sv/bgr_pkg.sv
sv/bgr_if.sv
sv/bgr_font_rom.sv
sv/bgr_sat_add.sv
sv/bitmap_glyph_rasterizer.sv
sv/bgr_checker.sv
verif/glyph_dot_checker.sv
verif/tb_top.sv
